// ===== rtl/core/lpht_pkg.sv =====
`default_nettype none

package lpht_pkg;

  localparam int unsigned TABLE_SLOTS = 256;
  localparam int unsigned PROBE_LIMIT = 8;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned PROBE_W     = $clog2(PROBE_LIMIT + 1);
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_SLOT_W  = 8;
  localparam int unsigned USED_W      = 9;
  localparam int unsigned MIX_STEPS   = 8;
  localparam int unsigned MIX_CNT_W   = $clog2(MIX_STEPS + 1);
  localparam int unsigned MIX_SEL_W   = $clog2(MIX_STEPS);
  localparam int unsigned HASH_PRE_SHIFT = 3;
  localparam logic [KEY_W-1:0] GOLDEN_MULT = 32'h9E3779B1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT  = 2'd0,
    ACT_REPLACE = 2'd1,
    ACT_LOOKUP  = 2'd2,
    ACT_REMOVE  = 2'd3
  } lpht_action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EXISTS    = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } lpht_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_RESP
  } lpht_state_e;

  // write side of the slot store
  typedef struct packed {
    logic              we;
    logic              set_valid;
    logic              clr_valid;
    logic [SLOT_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [VALUE_W-1:0] value;
  } store_wr_t;

  // read side of the slot store
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } store_rd_req_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } store_rd_t;

  function automatic logic [4:0] mix_shamt(input logic [MIX_SEL_W-1:0] s);
    logic [4:0] amt;
    unique case (s)
      3'd0:    amt = 5'd12;
      3'd1:    amt = 5'd22;
      3'd2:    amt = 5'd4;
      3'd3:    amt = 5'd9;
      3'd4:    amt = 5'd10;
      3'd5:    amt = 5'd2;
      3'd6:    amt = 5'd7;
      default: amt = 5'd12;
    endcase
    return amt;
  endfunction

  // even steps add a left-shifted copy, odd steps fold in a right-shifted copy
  function automatic logic [KEY_W-1:0] mix_step(input logic [KEY_W-1:0] h,
                                                input logic [MIX_SEL_W-1:0] s);
    logic [4:0]       amt;
    logic [KEY_W-1:0] r;
    amt = mix_shamt(s);
    if (!s[0]) begin
      r = h + (h << amt);
    end else begin
      r = h ^ (h >> amt);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lpht_if.sv =====
`default_nettype none

interface lpht_req_if;
  logic                          valid;
  logic                          ready;
  logic [lpht_pkg::ACTION_W-1:0] action;
  logic [lpht_pkg::KEY_W-1:0]    key;
  logic [lpht_pkg::VALUE_W-1:0]  new_value;

  modport source (output valid, action, key, new_value, input ready);
  modport sink   (input valid, action, key, new_value, output ready);
endinterface

interface lpht_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [lpht_pkg::STATUS_W-1:0]   status;
  logic [lpht_pkg::OUT_SLOT_W-1:0] slot_index;
  logic [lpht_pkg::VALUE_W-1:0]    stored_value;
  logic [lpht_pkg::USED_W-1:0]     entries_used;

  modport source (output valid, status, slot_index, stored_value, entries_used,
                  input ready);
  modport sink   (input valid, status, slot_index, stored_value, entries_used,
                  output ready);
endinterface

interface lpht_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lpht_pkg::USED_W-1:0] max_used_entries;

  modport source (output valid, max_used_entries, input ready);
  modport sink   (input valid, max_used_entries, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lpht_hash.sv =====
`default_nettype none

module lpht_hash (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [lpht_pkg::KEY_W-1:0]    key_i,
  output logic                               done_o,
  output logic      [lpht_pkg::SLOT_W-1:0]   slot_o
);

  logic                             run_q, run_d;
  logic                             done_q, done_d;
  logic [lpht_pkg::MIX_CNT_W-1:0]   step_q, step_d;
  logic [lpht_pkg::KEY_W-1:0]       h_q, h_d;
  logic [lpht_pkg::SLOT_W-1:0]      slot_q, slot_d;
  logic [lpht_pkg::KEY_W-1:0]       prod;
  logic                             mix_last;

  assign mix_last = (step_q == lpht_pkg::MIX_CNT_W'(lpht_pkg::MIX_STEPS));
  assign prod     = (h_q >> lpht_pkg::HASH_PRE_SHIFT) * lpht_pkg::GOLDEN_MULT;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    h_d    = h_q;
    slot_d = slot_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      h_d    = key_i;
    end else if (run_q) begin
      if (mix_last) begin
        // home slot is the product modulo the table size
        slot_d = prod[lpht_pkg::SLOT_W-1:0];
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        h_d    = lpht_pkg::mix_step(h_q, step_q[lpht_pkg::MIX_SEL_W-1:0]);
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    slot_q <= slot_d;
  end

  assign done_o = done_q;
  assign slot_o = slot_q;

endmodule

`default_nettype wire

// ===== rtl/core/lpht_store.sv =====
`default_nettype none

module lpht_store (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lpht_pkg::store_wr_t     wr_i,
  input  wire lpht_pkg::store_rd_req_t rd_req_i,
  output lpht_pkg::store_rd_t          rd_o
);

  localparam int unsigned ENTRY_W = lpht_pkg::KEY_W + lpht_pkg::VALUE_W;

  logic [lpht_pkg::TABLE_SLOTS-1:0] valid_q;
  logic [ENTRY_W-1:0]               mem [lpht_pkg::TABLE_SLOTS];
  logic [ENTRY_W-1:0]               rd_entry_q;
  logic                             rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.set_valid) begin
      valid_q[wr_i.addr] <= 1'b1;
    end else if (wr_i.clr_valid) begin
      valid_q[wr_i.addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= {wr_i.key, wr_i.value};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      rd_entry_q <= mem[rd_req_i.addr];
      rd_valid_q <= valid_q[rd_req_i.addr];
    end
  end

  assign rd_o.valid = rd_valid_q;
  assign rd_o.key   = rd_entry_q[ENTRY_W-1:lpht_pkg::VALUE_W];
  assign rd_o.value = rd_entry_q[lpht_pkg::VALUE_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/linear_probe_hash_table.sv =====
// Channel | Dir | Handshake   | Word
// req_i   | in  | valid/ready | action, key, new_value
// rsp_o   | out | valid/ready | status, slot_index, stored_value, entries_used
// cfg_i   | in  | valid/ready | max_used_entries (always ready)
//
// A request runs the key through one shared shift/add/xor unit eight times and one
// multiply, then each probed slot, up to 8 of them, costs a registered read of the
// slot memory (one read port, one write port) and a check.
// Reset clears every slot valid bit at once; no clearing pass is needed.
// req_i is ready only when idle; the result word holds until rsp_o is taken.
`default_nettype none

module linear_probe_hash_table (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lpht_req_if.sink    req_i,
  lpht_rsp_if.source  rsp_o,
  lpht_cfg_if.sink    cfg_i
);

  lpht_pkg::lpht_state_e   state_q, state_d;
  lpht_pkg::lpht_action_e  action_q, action_d;
  lpht_pkg::lpht_status_e  status_q, status_d;
  logic [lpht_pkg::KEY_W-1:0]   key_q, key_d;
  logic [lpht_pkg::VALUE_W-1:0] value_q, value_d;
  logic [lpht_pkg::VALUE_W-1:0] res_val_q, res_val_d;
  logic [lpht_pkg::SLOT_W-1:0]  idx_q, idx_d;
  logic [lpht_pkg::SLOT_W-1:0]  res_slot_q, res_slot_d;
  logic [lpht_pkg::PROBE_W-1:0] probe_q, probe_d;
  logic [lpht_pkg::USED_W-1:0]  used_q, used_d;
  logic [lpht_pkg::USED_W-1:0]  max_q;

  logic                         req_acc;
  logic                         hash_done;
  logic [lpht_pkg::SLOT_W-1:0]  hash_slot;
  lpht_pkg::store_wr_t          st_wr;
  lpht_pkg::store_rd_req_t      st_rd_req;
  lpht_pkg::store_rd_t          st_rd;

  logic is_insert, hit, is_free, has_room, last_probe, finish;

  assign req_acc    = req_i.valid && req_i.ready;
  assign is_insert  = (action_q == lpht_pkg::ACT_INSERT);
  assign hit        = st_rd.valid && (st_rd.key == key_q);
  assign is_free    = !st_rd.valid;
  assign has_room   = (used_q < max_q);
  assign last_probe = (probe_q == lpht_pkg::PROBE_W'(lpht_pkg::PROBE_LIMIT - 1));
  assign finish     = hit || last_probe || (is_insert && is_free);

  lpht_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (req_acc),
    .key_i   (req_i.key),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  lpht_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (st_wr),
    .rd_req_i (st_rd_req),
    .rd_o     (st_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpht_pkg::ST_IDLE:  if (req_acc) state_d = lpht_pkg::ST_HASH;
      lpht_pkg::ST_HASH:  if (hash_done) state_d = lpht_pkg::ST_READ;
      lpht_pkg::ST_READ:  state_d = lpht_pkg::ST_CHECK;
      lpht_pkg::ST_CHECK: state_d = finish ? lpht_pkg::ST_RESP : lpht_pkg::ST_READ;
      lpht_pkg::ST_RESP:  if (rsp_o.ready) state_d = lpht_pkg::ST_IDLE;
      default:            state_d = lpht_pkg::ST_IDLE;
    endcase
  end

  // store controls
  always_comb begin
    st_rd_req.en   = (state_q == lpht_pkg::ST_READ);
    st_rd_req.addr = idx_q;
    st_wr.we        = 1'b0;
    st_wr.set_valid = 1'b0;
    st_wr.clr_valid = 1'b0;
    st_wr.addr      = idx_q;
    st_wr.key       = key_q;
    st_wr.value     = value_q;
    if (state_q == lpht_pkg::ST_CHECK) begin
      if (is_insert) begin
        if (!hit && is_free && has_room) begin
          st_wr.we        = 1'b1;
          st_wr.set_valid = 1'b1;
        end
      end else if (hit) begin
        st_wr.we        = (action_q == lpht_pkg::ACT_REPLACE);
        st_wr.clr_valid = (action_q == lpht_pkg::ACT_REMOVE);
      end
    end
  end

  // request and result registers
  always_comb begin
    action_d   = action_q;
    key_d      = key_q;
    value_d    = value_q;
    idx_d      = idx_q;
    probe_d    = probe_q;
    used_d     = used_q;
    status_d   = status_q;
    res_slot_d = res_slot_q;
    res_val_d  = res_val_q;
    unique case (state_q)
      lpht_pkg::ST_IDLE: begin
        if (req_acc) begin
          action_d = lpht_pkg::lpht_action_e'(req_i.action);
          key_d    = req_i.key;
          value_d  = req_i.new_value;
        end
      end
      lpht_pkg::ST_HASH: begin
        idx_d   = hash_slot;
        probe_d = '0;
      end
      lpht_pkg::ST_CHECK: begin
        res_slot_d = '0;
        res_val_d  = '0;
        if (hit) begin
          res_slot_d = idx_q;
          if (is_insert) begin
            status_d  = lpht_pkg::STAT_EXISTS;
            res_val_d = st_rd.value;
          end else begin
            status_d  = lpht_pkg::STAT_OK;
            res_val_d = (action_q == lpht_pkg::ACT_REPLACE) ? value_q : st_rd.value;
            if (action_q == lpht_pkg::ACT_REMOVE && used_q != '0) begin
              used_d = used_q - 1'b1;
            end
          end
        end else if (is_insert && is_free) begin
          if (has_room) begin
            status_d   = lpht_pkg::STAT_OK;
            res_slot_d = idx_q;
            res_val_d  = value_q;
            used_d     = used_q + 1'b1;
          end else begin
            status_d = lpht_pkg::STAT_FULL;
          end
        end else if (last_probe) begin
          status_d = is_insert ? lpht_pkg::STAT_FULL : lpht_pkg::STAT_NOT_FOUND;
        end else begin
          // advance to the next slot, wrapping at the table end
          idx_d   = idx_q + 1'b1;
          probe_d = probe_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpht_pkg::ST_IDLE;
      used_q  <= '0;
      max_q   <= lpht_pkg::USED_W'(128);
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (cfg_i.valid && cfg_i.ready) begin
        max_q <= cfg_i.max_used_entries;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    action_q   <= action_d;
    key_q      <= key_d;
    value_q    <= value_d;
    idx_q      <= idx_d;
    probe_q    <= probe_d;
    status_q   <= status_d;
    res_slot_q <= res_slot_d;
    res_val_q  <= res_val_d;
  end

  assign req_i.ready = (state_q == lpht_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid        = (state_q == lpht_pkg::ST_RESP);
  assign rsp_o.status       = status_q;
  assign rsp_o.slot_index   = lpht_pkg::OUT_SLOT_W'(res_slot_q);
  assign rsp_o.stored_value = res_val_q;
  assign rsp_o.entries_used = used_q;

endmodule

`default_nettype wire
